// ===== src/complex_arithmetic_unit_assert.svh =====
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// Shared types, constants and saturation helpers for the complex arithmetic unit.
package cau_pkg;

   localparam int FracBitsDefault = 16;
   localparam int QuoBits         = 33;

   localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
   localparam logic [31:0] SatNeg = 32'h8000_0000;

   typedef enum logic [2:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_NEG = 3'd4
   } kind_type;

   typedef struct packed {
      logic [63:0]         rem;
      logic [QuoBits-1:0]  nlo;
      logic [QuoBits-1:0]  quo;
      logic                neg;
      logic                big;
   } lane_type;

   typedef struct packed {
      logic        div_op;
      logic        dz;
      logic        ovf;
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic [63:0] den;
      lane_type    re;
      lane_type    im;
   } dpipe_type;

   typedef struct packed {
      logic        ovf;
      logic [31:0] val;
   } sat_type;

   // Clamp a 33-bit signed sum to 32 bits.
   function automatic sat_type sat_sum(input logic [32:0] s);
      sat_type r;
      r.ovf = s[32] ^ s[31];
      if (r.ovf) begin
         r.val = s[32] ? SatNeg : SatPos;
      end else begin
         r.val = s[31:0];
      end
      return r;
   endfunction

   // Clamp a sign and magnitude to 32-bit two's complement.
   function automatic sat_type sat_mag(input logic neg, input logic [63:0] mag);
      sat_type r;
      r.ovf = 1'b0;
      if (!neg) begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            r.ovf = 1'b1;
            r.val = SatPos;
         end else begin
            r.val = mag[31:0];
         end
      end else begin
         if (mag > 64'h0000_0000_8000_0000) begin
            r.ovf = 1'b1;
            r.val = SatNeg;
         end else begin
            r.val = (~mag[31:0]) + 32'd1;
         end
      end
      return r;
   endfunction

endpackage

// ===== src/cau_front.sv =====
// Front stages: products, sums, magnitudes and divider set-up.
module cau_front import cau_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  logic [2:0]         kind,
   input  logic signed [31:0] a_re,
   input  logic signed [31:0] a_im,
   input  logic signed [31:0] b_re,
   input  logic signed [31:0] b_im,
   output logic               out_vld,
   output dpipe_type          out
);

   localparam int NW = 64 + FRAC_BITS;

   // stage A
   logic               vld_a_ff;
   kind_type           kind_a_ff;
   logic [31:0]        res_re_a_ff, res_im_a_ff;
   logic               ovf_a_ff;
   logic signed [63:0] p_rr_a_ff, p_ii_a_ff, p_ri_a_ff, p_ir_a_ff;
   logic [63:0]        sq_r_a_ff, sq_i_a_ff;

   kind_type           kind_in;
   logic signed [32:0] sum_re_in, sum_im_in;
   sat_type            sat_re_a, sat_im_a;
   logic signed [63:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, sq_r_in, sq_i_in;

   assign kind_in = kind_type'(kind);

   always_comb begin
      case (kind_in)
         KIND_ADD: begin
            sum_re_in = {a_re[31], a_re} + {b_re[31], b_re};
            sum_im_in = {a_im[31], a_im} + {b_im[31], b_im};
         end
         KIND_SUB: begin
            sum_re_in = {a_re[31], a_re} - {b_re[31], b_re};
            sum_im_in = {a_im[31], a_im} - {b_im[31], b_im};
         end
         KIND_NEG: begin
            sum_re_in = 33'sd0 - {a_re[31], a_re};
            sum_im_in = 33'sd0 - {a_im[31], a_im};
         end
         default: begin
            sum_re_in = 33'sd0;
            sum_im_in = 33'sd0;
         end
      endcase
   end

   assign sat_re_a = sat_sum(sum_re_in);
   assign sat_im_a = sat_sum(sum_im_in);
   assign p_rr_in  = 64'(a_re) * 64'(b_re);
   assign p_ii_in  = 64'(a_im) * 64'(b_im);
   assign p_ri_in  = 64'(a_re) * 64'(b_im);
   assign p_ir_in  = 64'(a_im) * 64'(b_re);
   assign sq_r_in  = 64'(b_re) * 64'(b_re);
   assign sq_i_in  = 64'(b_im) * 64'(b_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff    <= in_vld;
         kind_a_ff   <= kind_in;
         res_re_a_ff <= sat_re_a.val;
         res_im_a_ff <= sat_im_a.val;
         ovf_a_ff    <= sat_re_a.ovf | sat_im_a.ovf;
         p_rr_a_ff   <= p_rr_in;
         p_ii_a_ff   <= p_ii_in;
         p_ri_a_ff   <= p_ri_in;
         p_ir_a_ff   <= p_ir_in;
         sq_r_a_ff   <= sq_r_in;
         sq_i_a_ff   <= sq_i_in;
      end
   end

   // stage B: cross sums and |b|^2
   logic               vld_b_ff;
   kind_type           kind_b_ff;
   logic [31:0]        res_re_b_ff, res_im_b_ff;
   logic               ovf_b_ff;
   logic signed [64:0] t_re_b_ff, t_im_b_ff;
   logic [63:0]        den_b_ff;

   logic signed [64:0] e_rr, e_ii, e_ri, e_ir, t_re_in, t_im_in;

   assign e_rr = {p_rr_a_ff[63], p_rr_a_ff};
   assign e_ii = {p_ii_a_ff[63], p_ii_a_ff};
   assign e_ri = {p_ri_a_ff[63], p_ri_a_ff};
   assign e_ir = {p_ir_a_ff[63], p_ir_a_ff};

   // divide multiplies by the conjugate of b
   assign t_re_in = (kind_a_ff == KIND_DIV) ? (e_rr + e_ii) : (e_rr - e_ii);
   assign t_im_in = (kind_a_ff == KIND_DIV) ? (e_ir - e_ri) : (e_ri + e_ir);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff    <= vld_a_ff;
         kind_b_ff   <= kind_a_ff;
         res_re_b_ff <= res_re_a_ff;
         res_im_b_ff <= res_im_a_ff;
         ovf_b_ff    <= ovf_a_ff;
         t_re_b_ff   <= t_re_in;
         t_im_b_ff   <= t_im_in;
         den_b_ff    <= sq_r_a_ff + sq_i_a_ff;
      end
   end

   // stage C: sign and magnitude
   logic        vld_c_ff;
   kind_type    kind_c_ff;
   logic [31:0] res_re_c_ff, res_im_c_ff;
   logic        ovf_c_ff, dz_c_ff;
   logic        neg_re_c_ff, neg_im_c_ff;
   logic [63:0] mag_re_c_ff, mag_im_c_ff, den_c_ff;

   logic [64:0] abs_re, abs_im;

   assign abs_re = t_re_b_ff[64] ? (~t_re_b_ff + 65'd1) : t_re_b_ff;
   assign abs_im = t_im_b_ff[64] ? (~t_im_b_ff + 65'd1) : t_im_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff    <= vld_b_ff;
         kind_c_ff   <= kind_b_ff;
         res_re_c_ff <= res_re_b_ff;
         res_im_c_ff <= res_im_b_ff;
         ovf_c_ff    <= ovf_b_ff;
         dz_c_ff     <= (kind_b_ff == KIND_DIV) && (den_b_ff == 64'd0);
         neg_re_c_ff <= t_re_b_ff[64];
         neg_im_c_ff <= t_im_b_ff[64];
         mag_re_c_ff <= abs_re[63:0];
         mag_im_c_ff <= abs_im[63:0];
         den_c_ff    <= den_b_ff;
      end
   end

   // stage D: finish multiply, set up restoring division
   logic      vld_d_ff;
   dpipe_type pipe_d_ff;
   dpipe_type pipe_d_in;

   sat_type        mul_re, mul_im;
   logic [NW-1:0]  num_re, num_im;
   logic [63:0]    hi_re, hi_im;

   assign mul_re = sat_mag(neg_re_c_ff, mag_re_c_ff >> FRAC_BITS);
   assign mul_im = sat_mag(neg_im_c_ff, mag_im_c_ff >> FRAC_BITS);
   assign num_re = NW'(mag_re_c_ff) << FRAC_BITS;
   assign num_im = NW'(mag_im_c_ff) << FRAC_BITS;
   assign hi_re  = 64'(num_re >> QuoBits);
   assign hi_im  = 64'(num_im >> QuoBits);

   always_comb begin
      pipe_d_in.div_op = (kind_c_ff == KIND_DIV);
      pipe_d_in.dz     = dz_c_ff;
      pipe_d_in.den    = den_c_ff;
      if (kind_c_ff == KIND_MUL) begin
         pipe_d_in.res_re = mul_re.val;
         pipe_d_in.res_im = mul_im.val;
         pipe_d_in.ovf    = mul_re.ovf | mul_im.ovf;
      end else begin
         pipe_d_in.res_re = res_re_c_ff;
         pipe_d_in.res_im = res_im_c_ff;
         pipe_d_in.ovf    = ovf_c_ff;
      end
      pipe_d_in.re.rem = hi_re;
      pipe_d_in.re.nlo = num_re[QuoBits-1:0];
      pipe_d_in.re.quo = '0;
      pipe_d_in.re.neg = neg_re_c_ff;
      pipe_d_in.re.big = (hi_re >= den_c_ff);
      pipe_d_in.im.rem = hi_im;
      pipe_d_in.im.nlo = num_im[QuoBits-1:0];
      pipe_d_in.im.quo = '0;
      pipe_d_in.im.neg = neg_im_c_ff;
      pipe_d_in.im.big = (hi_im >= den_c_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
      end else if (en) begin
         vld_d_ff  <= vld_c_ff;
         pipe_d_ff <= pipe_d_in;
      end
   end

   assign out_vld = vld_d_ff;
   assign out     = pipe_d_ff;

endmodule

// ===== src/cau_div_step.sv =====
// One restoring division step for both result lanes.
module cau_div_step import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_vld,
   input  dpipe_type in,
   output logic      out_vld,
   output dpipe_type out
);

   logic      vld_ff;
   dpipe_type pipe_ff;
   dpipe_type pipe_in;

   function automatic lane_type step(input lane_type l, input logic [63:0] den);
      logic [64:0] t;
      logic [64:0] diff;
      logic        ge;
      lane_type    r;
      t      = {l.rem, l.nlo[QuoBits-1]};
      diff   = t - {1'b0, den};
      ge     = (t >= {1'b0, den});
      r      = l;
      r.rem  = ge ? diff[63:0] : t[63:0];
      r.nlo  = {l.nlo[QuoBits-2:0], 1'b0};
      r.quo  = {l.quo[QuoBits-2:0], ge};
      return r;
   endfunction

   always_comb begin
      pipe_in    = in;
      pipe_in.re = step(in.re, in.den);
      pipe_in.im = step(in.im, in.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= in_vld;
         pipe_ff <= pipe_in;
      end
   end

   assign out_vld = vld_ff;
   assign out     = pipe_ff;

endmodule

// ===== src/cau_back.sv =====
// Final stage: clamp quotients, apply divide-by-zero, hold the result beat.
module cau_back import cau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  dpipe_type          in,
   output logic               out_vld,
   output logic signed [31:0] res_re,
   output logic signed [31:0] res_im,
   output logic               div_zero,
   output logic               overflow
);

   logic        vld_ff;
   logic [31:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic        dz_ff, ovf_ff, dz_in, ovf_in;
   sat_type     q_re, q_im;

   assign q_re = sat_mag(in.re.neg, in.re.big ? 64'h1_0000_0000 : 64'(in.re.quo));
   assign q_im = sat_mag(in.im.neg, in.im.big ? 64'h1_0000_0000 : 64'(in.im.quo));

   always_comb begin
      res_re_in = in.res_re;
      res_im_in = in.res_im;
      ovf_in    = in.ovf;
      dz_in     = 1'b0;
      if (in.div_op) begin
         if (in.dz) begin
            res_re_in = '0;
            res_im_in = '0;
            ovf_in    = 1'b0;
            dz_in     = 1'b1;
         end else begin
            res_re_in = q_re.val;
            res_im_in = q_im.val;
            ovf_in    = q_re.ovf | q_im.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff    <= in_vld;
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign out_vld  = vld_ff;
   assign res_re   = res_re_ff;
   assign res_im   = res_im_ff;
   assign div_zero = dz_ff;
   assign overflow = ovf_ff;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Top level of the pipelined Q16.16 complex arithmetic unit.
// Complex ALU on signed fixed-point parts: add, subtract, multiply, divide and
// negate, one beat per cycle unless a held result stalls the pipe. Every
// operation runs the same 38-stage pipeline: four front stages (products,
// cross sums, magnitudes, divider set-up), one restoring-division stage per
// quotient bit (33 of them) and a final clamp stage that is also the result
// register. The whole pipeline advances together: it moves whenever the
// result register is empty or its beat is being taken, and req_ready follows
// that same enable, so a stalled result holds every stage and nothing is
// dropped or repeated. Results that leave the 32-bit range clamp and raise
// overflow; divide with b equal to zero gives zero parts and raises div_zero.
// Selector codes above negate give zero with no flags.
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_a_re,
   input  logic signed [31:0] req_a_im,
   input  logic signed [31:0] req_b_re,
   input  logic signed [31:0] req_b_im,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_re,
   output logic signed [31:0] rsp_res_im,
   output logic               rsp_div_zero,
   output logic               rsp_overflow
);

   // advance the whole pipe unless the result beat is held
   logic pipe_en;
   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;

   logic      dv_vld  [QuoBits+1];
   dpipe_type dv_pipe [QuoBits+1];

   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .in_vld  (req_valid),
      .kind    (req_kind),
      .a_re    (req_a_re),
      .a_im    (req_a_im),
      .b_re    (req_b_re),
      .b_im    (req_b_im),
      .out_vld (dv_vld[0]),
      .out     (dv_pipe[0])
   );

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < QuoBits; i++) begin : g_div
      cau_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (pipe_en),
         .in_vld  (dv_vld[i]),
         .in      (dv_pipe[i]),
         .out_vld (dv_vld[i+1]),
         .out     (dv_pipe[i+1])
      );
   end

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (dv_vld[QuoBits]),
      .in       (dv_pipe[QuoBits]),
      .out_vld  (rsp_valid),
      .res_re   (rsp_res_re),
      .res_im   (rsp_res_im),
      .div_zero (rsp_div_zero),
      .overflow (rsp_overflow)
   );

   // divide by zero always gives clean zero parts
   `CAU_ASSERT_SAME(a_dz_zero, rsp_valid && rsp_div_zero, (rsp_res_re == 32'sd0) && (rsp_res_im == 32'sd0) && !rsp_overflow, "div_zero beat with non-zero parts or overflow")

   // overflow means at least one part sits on a bound
   `CAU_ASSERT_SAME(a_ovf_bound, rsp_valid && rsp_overflow, (rsp_res_re == SatPos) || (rsp_res_re == SatNeg) || (rsp_res_im == SatPos) || (rsp_res_im == SatNeg), "overflow beat without a clamped part")

   // a stalled beat in the divider entry stage is held, not dropped
   `CAU_ASSERT_NEXT(a_stall_hold, !pipe_en && dv_vld[0], dv_vld[0], "beat lost from divider entry during stall")

endmodule
